>>> hw/rtl/arl_pkg.sv
// Shared types and constants for the address range lookup block.
// No dependencies; imported by every module of the block.
`default_nettype none

package arl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 16;

  // Item kinds
  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_LOOKUP = 1'b1
  } arl_kind_t;

  // Add status codes
  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } arl_status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DONE
  } arl_state_t;

  // One stored range entry
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [TAG_W-1:0]  tag;
  } arl_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;         // capture the accepted transaction
    logic scan_start;    // rewind the scan pointer
    logic scan_step;     // read the next entry
    logic scan_capture;  // record the lookup result
    logic add_exec;      // append entry or flag full, record result
    logic out_load;      // move the result into the output register
  } arl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;        // entry read last cycle covers the address
    logic exhausted;  // every stored entry has been compared
    logic out_free;   // output register can take a result this cycle
  } arl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/address_range_lookup.sv
// Top level of the address range lookup block: first-match search over an
// ordered table of IPv4 ranges. Instantiates arl_ctrl and arl_dpath; uses arl_pkg.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  in_kind, in_address, in_range_low,
//                                 in_range_high, in_entry_tag
//   out      out_valid/out_ready  out_found, out_match_tag, out_status
//
// One transaction at a time. An add goes from accept through ST_ADD and ST_DONE to its
// result load. A lookup reads one entry per scan step over the single memory read port,
// up to the first hit or until every stored entry (at most TABLE_DEPTH) is compared.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile, and only its result load stalls until out_ready.
// Synchronous active-low reset empties the table; entry contents are not cleared.
`default_nettype none

module address_range_lookup (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_kind,
  input  wire logic [arl_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [arl_pkg::ADDR_W-1:0]  in_range_low,
  input  wire logic [arl_pkg::ADDR_W-1:0]  in_range_high,
  input  wire logic [arl_pkg::TAG_W-1:0]   in_entry_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic [arl_pkg::TAG_W-1:0]        out_match_tag,
  output logic                             out_status
);
  import arl_pkg::*;

  arl_cmd_t cmd;
  arl_sts_t sts;

  // Sequencing
  arl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, compare and result registers
  arl_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_address    (in_address),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .in_entry_tag  (in_entry_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_match_tag (out_match_tag),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

>>> hw/rtl/arl_ctrl.sv
// Controller state machine for the address range lookup block.
// Depends on arl_pkg for the state, command and status types.
`default_nettype none

module arl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  output logic                   in_ready,
  input  wire arl_pkg::arl_sts_t sts,
  output arl_pkg::arl_cmd_t      cmd
);
  import arl_pkg::*;

  arl_state_t state_r;
  arl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // take nothing while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.latch = 1'b1;
          if (arl_kind_t'(in_kind) == KIND_LOOKUP) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd.add_exec = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_SCAN: begin
        // stop at the first hit or when the table runs out
        if (sts.hit || sts.exhausted) begin
          cmd.scan_capture = 1'b1;
          state_nxt        = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/arl_dpath.sv
// Datapath for the address range lookup block: entry memory, scan pointer,
// range compare, result and output registers. Depends on arl_pkg.
`default_nettype none

module arl_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire arl_pkg::arl_cmd_t           cmd,
  output arl_pkg::arl_sts_t                sts,
  input  wire logic [arl_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [arl_pkg::ADDR_W-1:0]  in_range_low,
  input  wire logic [arl_pkg::ADDR_W-1:0]  in_range_high,
  input  wire logic [arl_pkg::TAG_W-1:0]   in_entry_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic [arl_pkg::TAG_W-1:0]        out_match_tag,
  output logic                             out_status
);
  import arl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // Entry storage
  arl_entry_t ent_mem [TABLE_DEPTH];

  // Latched transaction
  logic [ADDR_W-1:0] addr_r;
  arl_entry_t        new_ent_r;

  // Control state
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             rd_vld_r;
  logic             out_valid_r;

  // Read data
  arl_entry_t rd_q_r;

  // Result holding and output registers
  logic             res_found_r;
  logic [TAG_W-1:0] res_tag_r;
  logic             res_status_r;
  logic             out_found_r;
  logic [TAG_W-1:0] out_tag_r;
  logic             out_status_r;

  logic more;
  logic full;
  logic hit;

  assign more = (idx_r < count_r);
  assign full = (count_r == DEPTH_C);
  assign hit  = rd_vld_r && (rd_q_r.lo <= addr_r) && (rd_q_r.hi >= addr_r);

  assign sts.hit       = hit;
  assign sts.exhausted = !more && !rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Hold the accepted transaction's payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      addr_r        <= in_address;
      new_ent_r.lo  <= in_range_low;
      new_ent_r.hi  <= in_range_high;
      new_ent_r.tag <= in_entry_tag;
    end
  end

  // Append entries
  always_ff @(posedge clk) begin
    if (cmd.add_exec && !full) begin
      ent_mem[count_r[IDX_W-1:0]] <= new_ent_r;
    end
  end

  // Read one entry per scan step
  always_ff @(posedge clk) begin
    if (cmd.scan_step && more) begin
      rd_q_r <= ent_mem[idx_r[IDX_W-1:0]];
    end
  end

  // Fill count, scan pointer and read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.add_exec && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld_r <= more;
        if (more) begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  // Record the result of the finished transaction
  always_ff @(posedge clk) begin
    if (cmd.add_exec) begin
      res_found_r  <= 1'b0;
      res_tag_r    <= '0;
      res_status_r <= full ? STATUS_FULL : STATUS_OK;
    end else if (cmd.scan_capture) begin
      res_found_r  <= hit;
      res_tag_r    <= hit ? rd_q_r.tag : '0;
      res_status_r <= STATUS_OK;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r  <= res_found_r;
      out_tag_r    <= res_tag_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_match_tag = out_tag_r;
  assign out_status    = out_status_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds table depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("scan pointer past fill count");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_exec && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted add did not grow the table");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire
